>>> hw/rtl/slrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrc_pkg: shared types and constants of the shape list raster compositor
// Entry layout, operation and status codes, sequencer states, defaults.
// ----------------------------------------------------------------------------
package slrc_pkg;

  localparam int COORD_BITS     = 8;
  localparam int BRUSH_W        = 8;
  localparam int STATUS_W       = 3;
  localparam int SLOT_W         = 4;
  localparam int CANVAS_W       = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_SHAPES = 16;

  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 9'd256;
  localparam logic [BRUSH_W-1:0]  EMPTY_PIXEL  = 8'd46;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_QRY = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_RECT = 2'd0,
    KIND_UP   = 2'd1,
    KIND_DOWN = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EVEN    = 3'd1,
    ST_BOUNDS  = 3'd2,
    ST_FULL    = 3'd3,
    ST_BAD_IDX = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMD  = 2'd1,
    S_SCAN = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    kind_t                 kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [BRUSH_W-1:0]    brush;
  } shape_entry_t;

  localparam int ENTRY_W = $bits(shape_entry_t);

endpackage

>>> hw/rtl/slrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrc_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/slrc_cover.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrc_cover: pixel coverage test
// Decides whether one table entry covers a pixel; reused for every entry.
// ----------------------------------------------------------------------------
module slrc_cover import slrc_pkg::*; (
  input  shape_entry_t          ent,
  input  logic [COORD_BITS-1:0] row,
  input  logic [COORD_BITS-1:0] col,
  output logic                  hit
);

  logic [COORD_BITS-1:0] dcol;
  logic [COORD_BITS-1:0] drow;
  logic [COORD_BITS-1:0] k_up;
  logic [COORD_BITS-1:0] k_dn;

  assign dcol = (col >= ent.x) ? (col - ent.x) : (ent.x - col);
  assign drow = (row >= ent.y) ? (row - ent.y) : (ent.y - row);
  assign k_up = row - ent.y;
  assign k_dn = ent.y - row;

  always_comb begin
    unique case (ent.kind)
      KIND_RECT: hit = (drow <= (ent.h >> 1)) && (dcol <= (ent.w >> 1));
      KIND_UP:   hit = (row >= ent.y) && (k_up < ent.h) && (dcol <= k_up);
      KIND_DOWN: hit = (ent.y >= row) && (k_dn < ent.h) && (dcol <= k_dn);
      default:   hit = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/shape_list_raster_compositor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_list_raster_compositor: ordered shape table with pixel queries
// Add, delete and pixel query over a table of rectangles and triangles.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command word per accept (add, delete, query pixel).
//   out_* : exactly one result word per command: status, slot, pixel.
//   cfg_* : canvas row and column count, written while the block is idle;
//           cfg_ready is always high.
// Flow: each accepted command is latched and checked in the command state,
//   then goes to the done state (add, bad delete, off-canvas query,
//   unused op) or walks the table first (query, good delete).
//   a query walks every entry; a delete at slot s walks from s + 1 on.
//   the table walk reads one entry per cycle from the single read port of
//   the shape ram and runs it through the one coverage unit.
// in_ready is high only while no command is in progress, so a new command is
// not taken before the last result is loaded; a finished result sits in the
// output register, so the next command may be accepted while the receiver
// stalls, but that command's result waits until the register is emptied.
// Reset: table empty, canvas 256 x 256; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shape_list_raster_compositor import slrc_pkg::*; #(
  parameter int MAX_SHAPES = DEF_MAX_SHAPES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [1:0]           in_shape_kind,
  input  logic [7:0]           in_center_x,
  input  logic [7:0]           in_center_y,
  input  logic [7:0]           in_shape_width,
  input  logic [7:0]           in_shape_height,
  input  logic [7:0]           in_brush_char,
  input  logic [3:0]           in_slot_index,
  input  logic [7:0]           in_pixel_row,
  input  logic [7:0]           in_pixel_col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [3:0]           out_slot_out,
  output logic [7:0]           out_pixel_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CANVAS_W-1:0]  cfg_data
);

  localparam int IDX_W  = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int CNT_W  = $clog2(MAX_SHAPES + 1);
  localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int SPAN_W = COORD_BITS + 2;

  // sequencer and table state
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CANVAS_W-1:0]   rows_r, cols_r;
  logic [CNT_W-1:0]      scan_ptr_r, scan_ptr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_addr_q_r, rd_addr_q_nxt;

  // latched command
  op_t                   op_r;
  kind_t                 kind_r;
  logic [COORD_BITS-1:0] cx_r, cy_r, w_r, h_r;
  logic [BRUSH_W-1:0]    brush_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [COORD_BITS-1:0] prow_r, pcol_r;

  // result being built and output register
  status_t               status_r, status_nxt;
  logic [SLOT_W-1:0]     slot_res_r, slot_res_nxt;
  logic [BRUSH_W-1:0]    pix_r, pix_nxt;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [BRUSH_W-1:0]    out_pix_r;

  // ram ports
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  shape_entry_t          wr_ent;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [ENTRY_W-1:0]    rd_data;
  shape_entry_t          rd_ent;
  shape_entry_t          new_ent;
  logic                  hit;

  // add checks
  logic signed [SPAN_W-1:0] sx, sy, half_w, half_h, ext;
  logic signed [SPAN_W-1:0] xmin, xmax, ymin, ymax;
  logic                     add_even, add_bounds, add_full, add_ok;
  logic                     del_bad, qry_on_canvas;
  logic                     issue, scan_end, in_fire, out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign sx     = $signed({2'b00, cx_r});
  assign sy     = $signed({2'b00, cy_r});
  assign half_w = $signed({2'b00, (w_r >> 1)});
  assign half_h = $signed({2'b00, (h_r >> 1)});
  assign ext    = $signed({2'b00, h_r}) - SPAN_W'(1);

  always_comb begin
    unique case (kind_r)
      KIND_RECT: begin
        xmin = sx - half_w;
        xmax = sx + half_w;
        ymin = sy - half_h;
        ymax = sy + half_h;
      end
      KIND_UP: begin
        xmin = sx - ext;
        xmax = sx + ext;
        ymin = sy;
        ymax = sy + ext;
      end
      KIND_DOWN: begin
        xmin = sx - ext;
        xmax = sx + ext;
        ymin = sy - ext;
        ymax = sy;
      end
      default: begin
        xmin = '0;
        xmax = '0;
        ymin = '0;
        ymax = '0;
      end
    endcase
  end

  assign add_even   = (kind_r == KIND_RECT) && (!w_r[0] || !h_r[0]);
  assign add_bounds = (xmin < 0) || (xmax >= $signed({1'b0, cols_r})) ||
                      (ymin < 0) || (ymax >= $signed({1'b0, rows_r}));
  assign add_full   = (count_r >= CNT_W'(MAX_SHAPES));
  assign add_ok     = !add_even && !add_bounds && !add_full;

  assign del_bad       = (CMP_W'(slot_r) >= CMP_W'(count_r));
  assign qry_on_canvas = ({1'b0, prow_r} < rows_r) && ({1'b0, pcol_r} < cols_r);

  assign issue    = (state_r == S_SCAN) && (scan_ptr_r < count_r);
  assign scan_end = (state_r == S_SCAN) && !issue && !rd_vld_r;

  assign new_ent.kind  = kind_r;
  assign new_ent.x     = cx_r;
  assign new_ent.y     = cy_r;
  assign new_ent.w     = w_r;
  assign new_ent.h     = h_r;
  assign new_ent.brush = brush_r;

  assign rd_ent  = shape_entry_t'(rd_data);
  assign rd_en   = issue;
  assign rd_addr = scan_ptr_r[IDX_W-1:0];

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        unique case (op_r)
          OP_DEL:  state_nxt = del_bad ? S_DONE : S_SCAN;
          OP_QRY:  state_nxt = qry_on_canvas ? S_SCAN : S_DONE;
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath control
  always_comb begin
    count_nxt     = count_r;
    scan_ptr_nxt  = scan_ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_addr_q_nxt = rd_addr;
    status_nxt    = status_r;
    slot_res_nxt  = slot_res_r;
    pix_nxt       = pix_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_ent        = new_ent;
    unique case (state_r)
      S_IDLE: begin
        status_nxt   = ST_OK;
        slot_res_nxt = '0;
        pix_nxt      = '0;
      end
      S_CMD: begin
        unique case (op_r)
          OP_ADD: begin
            priority if (add_even) begin
              status_nxt = ST_EVEN;
            end else if (add_bounds) begin
              status_nxt = ST_BOUNDS;
            end else if (add_full) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en        = 1'b1;
              slot_res_nxt = SLOT_W'(count_r);
              count_nxt    = count_r + CNT_W'(1);
            end
          end
          OP_DEL: begin
            if (del_bad) begin
              status_nxt = ST_BAD_IDX;
            end
            // walk starts at the entry after the deleted one
            scan_ptr_nxt = CNT_W'(slot_r) + CNT_W'(1);
          end
          OP_QRY: begin
            pix_nxt      = EMPTY_PIXEL;
            scan_ptr_nxt = '0;
          end
          default: begin
            pix_nxt = '0;
          end
        endcase
      end
      S_SCAN: begin
        rd_vld_nxt = issue;
        if (issue) begin
          scan_ptr_nxt = scan_ptr_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (op_r == OP_QRY) begin
            if (hit) begin
              pix_nxt = rd_ent.brush;
            end
          end else begin
            // compaction: move the word just read down one place
            wr_en   = 1'b1;
            wr_addr = rd_addr_q_r - IDX_W'(1);
            wr_ent  = rd_ent;
          end
        end
        if (scan_end && (op_r == OP_DEL)) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rows_r      <= CANVAS_RESET;
      cols_r      <= CANVAS_RESET;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROWS: rows_r <= cfg_data;
          CFG_COLS: cols_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r  <= scan_ptr_nxt;
    rd_addr_q_r <= rd_addr_q_nxt;
    status_r    <= status_nxt;
    slot_res_r  <= slot_res_nxt;
    pix_r       <= pix_nxt;
    if (in_fire) begin
      op_r    <= op_t'(in_op);
      kind_r  <= kind_t'(in_shape_kind);
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      w_r     <= in_shape_width;
      h_r     <= in_shape_height;
      brush_r <= in_brush_char;
      slot_r  <= in_slot_index;
      prow_r  <= in_pixel_row;
      pcol_r  <= in_pixel_col;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_slot_r   <= slot_res_r;
      out_pix_r    <= pix_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_out    = out_slot_r;
  assign out_pixel_value = out_pix_r;

  // ---------------------------------------------------------------- units
  slrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SHAPES),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  slrc_cover u_cover (
    .ent (rd_ent),
    .row (prow_r),
    .col (pcol_r),
    .hit (hit)
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SHAPES))
    else $error("shape count beyond table size");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == S_CMD) && (op_r == OP_ADD)) ||
              ((state_r == S_SCAN) && (op_r == OP_DEL)))
    else $error("table written outside add or delete");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CMD) && (op_r == OP_ADD) && add_ok) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("successful add did not grow the table");

  a_scan_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
    scan_end |=> (state_r == S_DONE) && !rd_vld_r)
    else $error("table walk did not hand over to result stage");
`endif

endmodule
